[design/fvt_pkg.sv]
`timescale 1ns / 1ps
// Package for the six-plane frustum visibility test: question kinds, widths
// and the item record that travels down the row of plane cells. No dependencies.
package fvt_pkg;

  // Number of plane registers on the configuration port.
  localparam int REG_COUNT = 6;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;
  // Width of one packed plane register.
  localparam int PLANE_W = 64;
  // Default number of planes tested.
  localparam int PLANE_COUNT_DEF = 6;

  // Coordinate widths: Q12.4 inputs, one bit wider after centre +/- half-width.
  localparam int COORD_W = 16;
  localparam int CORNER_W = 17;
  localparam int EXT_W = 15;
  // Q1.15 normal component.
  localparam int NORM_W = 16;
  // Product of a normal and a corner coordinate, 19 fraction bits.
  localparam int PROD_W = NORM_W + CORNER_W;
  // Plane sum: three products plus scaled distance and radius, with headroom.
  localparam int SUM_W = 36;
  // Shift that brings Q12.4 up to 19 fraction bits.
  localparam int FRAC_SHIFT = 15;

  // Question kinds.
  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_SPHERE = 2'd1,
    KIND_BOX    = 2'd2,
    KIND_CUBE   = 2'd3
  } fvt_kind_t;

  // One item in flight. For a box or a cube, qhi and qlo hold the larger and
  // smaller coordinate on each axis; for a point or a sphere both hold the centre.
  typedef struct packed {
    fvt_kind_t                    kind;
    logic [2:0][CORNER_W-1:0]     qhi;
    logic [2:0][CORNER_W-1:0]     qlo;
    logic [EXT_W-1:0]             ext;
    logic                         vis;
  } fvt_item_t;

endpackage

[design/fvt_prep.sv]
`timescale 1ns / 1ps
// Input stage of the frustum test: forms the per-axis extreme coordinates of
// each item and registers them. Depends on fvt_pkg.
module fvt_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  logic [1:0]                          kind,
  input  logic signed [fvt_pkg::COORD_W-1:0]  ax,
  input  logic signed [fvt_pkg::COORD_W-1:0]  ay,
  input  logic signed [fvt_pkg::COORD_W-1:0]  az,
  input  logic signed [fvt_pkg::COORD_W-1:0]  bx,
  input  logic signed [fvt_pkg::COORD_W-1:0]  by_coord,
  input  logic signed [fvt_pkg::COORD_W-1:0]  bz,
  input  logic [fvt_pkg::EXT_W-1:0]           extent,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output fvt_pkg::fvt_item_t                  dn_item
);
  import fvt_pkg::*;

  logic                              valid_r, valid_nxt;
  fvt_item_t                         item_r, item_nxt;
  logic signed [2:0][COORD_W-1:0]    a_vec;
  logic signed [2:0][COORD_W-1:0]    b_vec;
  logic signed [CORNER_W-1:0]        a_w, b_w, e_w;

  assign a_vec = {az, ay, ax};
  assign b_vec = {bz, by_coord, bx};

  // Per-axis corner extremes, each axis on its own. An element of a packed
  // array reads as unsigned, so it is made signed before it is widened.
  always_comb begin
    item_nxt.kind = fvt_kind_t'(kind);
    item_nxt.ext  = extent;
    item_nxt.vis  = 1'b1;
    e_w = CORNER_W'($signed({1'b0, extent}));
    for (int k = 0; k < 3; k++) begin
      a_w = CORNER_W'($signed(a_vec[k]));
      b_w = CORNER_W'($signed(b_vec[k]));
      case (item_nxt.kind)
        KIND_BOX: begin
          item_nxt.qhi[k] = (a_w > b_w) ? a_w : b_w;
          item_nxt.qlo[k] = (a_w > b_w) ? b_w : a_w;
        end
        KIND_CUBE: begin
          item_nxt.qhi[k] = a_w + e_w;
          item_nxt.qlo[k] = a_w - e_w;
        end
        default: begin
          item_nxt.qhi[k] = a_w;
          item_nxt.qlo[k] = a_w;
        end
      endcase
    end
  end

  // Stage register moves whenever it is empty or the next cell takes its item.
  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item_r <= item_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_item  = item_r;

endmodule

[design/fvt_cell.sv]
`timescale 1ns / 1ps
// One plane cell of the frustum test: multiplies the best corner by the plane
// normal, then sums, compares and folds the result into the visible flag.
// Depends on fvt_pkg.
module fvt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [fvt_pkg::PLANE_W-1:0]   plane,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  fvt_pkg::fvt_item_t            up_item,
  output logic                          dn_valid,
  input  logic                          dn_ready,
  output fvt_pkg::fvt_item_t            dn_item
);
  import fvt_pkg::*;

  logic                          a_valid_r, a_valid_nxt, a_ready;
  fvt_item_t                     a_item_r;
  logic signed [PROD_W-1:0]      a_prod_r [3];
  logic signed [PROD_W-1:0]      prod_nxt [3];
  logic                          b_valid_r, b_valid_nxt, b_ready;
  fvt_item_t                     b_item_r, b_item_nxt;
  logic signed [NORM_W-1:0]      n_k;
  logic signed [CORNER_W-1:0]    q_k;
  logic signed [COORD_W-1:0]     plane_d;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SUM_W-1:0]       dist_term;
  logic signed [SUM_W-1:0]       ext_term;

  // Multiply stage: on each axis take the corner coordinate that pushes n.q
  // furthest forward, which makes the best corner of the box.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_k = plane[NORM_W*(3-k) + NORM_W-1 -: NORM_W];
      q_k = n_k[NORM_W-1] ? $signed(up_item.qlo[k]) : $signed(up_item.qhi[k]);
      prod_nxt[k] = PROD_W'(n_k) * PROD_W'(q_k);
    end
  end

  assign a_ready     = !a_valid_r || b_ready;
  assign a_valid_nxt = a_ready ? up_valid : a_valid_r;
  assign up_ready    = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && up_valid) begin
      a_item_r <= up_item;
      for (int k = 0; k < 3; k++) begin
        a_prod_r[k] <= prod_nxt[k];
      end
    end
  end

  // Sum stage: n.q + d, plus the radius for a sphere, must be above zero.
  always_comb begin
    plane_d   = plane[COORD_W-1:0];
    dist_term = SUM_W'(plane_d) <<< FRAC_SHIFT;
    ext_term  = (a_item_r.kind == KIND_SPHERE) ?
                SUM_W'({a_item_r.ext, {FRAC_SHIFT{1'b0}}}) : '0;
    sum = SUM_W'(a_prod_r[0]) + SUM_W'(a_prod_r[1]) + SUM_W'(a_prod_r[2])
        + dist_term + ext_term;
    b_item_nxt     = a_item_r;
    b_item_nxt.vis = a_item_r.vis && (sum > 0);
  end

  assign b_ready     = !b_valid_r || dn_ready;
  assign b_valid_nxt = b_ready ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign dn_valid = b_valid_r;
  assign dn_item  = b_item_r;

endmodule

[design/frustum_visibility_test_top.sv]
`timescale 1ns / 1ps
// Top level of the frustum visibility test: plane registers, input stage and
// a row of plane cells. Depends on fvt_pkg, fvt_prep and fvt_cell.
//
// The block takes one point, sphere, box or cube item per clock while
// in_stall is low and returns one visible flag per item, in order. Each item
// passes an input stage and then one cell per plane, where every cell has a
// multiply stage and a sum stage, so the row holds 2*PLANE_COUNT+1 items. A
// flag is offered on the output from the last sum stage and is taken when
// the output is not stalled. Every stage has its own valid bit, so the row
// fills gaps and keeps taking items while a finished flag waits, until every
// stage is full. Planes are loaded through the cfg_ port (register 0 right,
// then left, bottom, top, far, near; higher indexes are ignored) and should
// only be written while no item is in flight. Planes beyond the sixth act
// as all-zero planes.
module frustum_visibility_test_top #(
  parameter int PLANE_COUNT = fvt_pkg::PLANE_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_kind,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_ax,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_ay,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_az,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_bx,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_by_coord,
  input  logic signed [fvt_pkg::COORD_W-1:0]  in_bz,
  input  logic [fvt_pkg::EXT_W-1:0]           in_extent,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_visible,
  input  logic                                cfg_wr_en,
  input  logic [fvt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fvt_pkg::PLANE_W-1:0]         cfg_wdata
);
  import fvt_pkg::*;

  logic [PLANE_W-1:0]  planes_r [REG_COUNT];
  logic                chain_valid [PLANE_COUNT+1];
  logic                chain_ready [PLANE_COUNT+1];
  fvt_item_t           chain_item  [PLANE_COUNT+1];
  logic                prep_ready;

  // Plane registers, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        planes_r[i] <= '0;
      end
    end else if (cfg_wr_en && (32'(cfg_index) < REG_COUNT)) begin
      planes_r[cfg_index] <= cfg_wdata;
    end
  end

  // Input stage.
  fvt_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (prep_ready),
    .kind     (in_kind),
    .ax       (in_ax),
    .ay       (in_ay),
    .az       (in_az),
    .bx       (in_bx),
    .by_coord (in_by_coord),
    .bz       (in_bz),
    .extent   (in_extent),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_item  (chain_item[0])
  );

  assign in_stall = !prep_ready;

  // One cell per plane; planes without a register are all zero.
  for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
    logic [PLANE_W-1:0] plane_w;
    if (g < REG_COUNT) begin : g_reg
      assign plane_w = planes_r[g];
    end else begin : g_zero
      assign plane_w = '0;
    end

    fvt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (plane_w),
      .up_valid (chain_valid[g]),
      .up_ready (chain_ready[g]),
      .up_item  (chain_item[g]),
      .dn_valid (chain_valid[g+1]),
      .dn_ready (chain_ready[g+1]),
      .dn_item  (chain_item[g+1])
    );
  end

  // The last cell's sum stage is the output register.
  assign chain_ready[PLANE_COUNT] = !out_stall;
  assign out_valid   = chain_valid[PLANE_COUNT];
  assign out_visible = chain_item[PLANE_COUNT].vis;

endmodule

[design/fvt_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the frustum visibility test and its bind onto the
// top level. Depends only on the top level's ports.
module fvt_checker #(
  parameter int PLANE_COUNT = 6
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_visible
);
  localparam int DEPTH = 2 * PLANE_COUNT + 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Items accepted but not yet delivered.
  always_comb begin
    count_nxt = count_r;
    if (in_acc && !out_acc) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its flag.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_visible))
    else $error("result changed while stalled");

  // No result without an outstanding item.
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> count_r != '0)
    else $error("result offered with no item in flight");

  // The row never holds more items than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= DEPTH)
    else $error("more items in flight than stages");

endmodule

bind frustum_visibility_test_top fvt_checker #(
  .PLANE_COUNT (PLANE_COUNT)
) u_fvt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_visible (out_visible)
);
